@@ hw/rtl/pal_pkg.sv @@
// Package for the positional array list unit: payload structs, command and
// status codes, and the control struct shared by the top level and its cells.
// No dependencies.
package pal_pkg;

    localparam int CAPACITY_DEF = 128;
    localparam int SCAN_GROUP   = 8;

    localparam logic [1:0] CMD_FIND   = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_DELETE = 2'd2;

    localparam logic [1:0] STAT_DONE      = 2'd0;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [1:0] STAT_FULL      = 2'd2;
    localparam logic [1:0] STAT_BAD_POS   = 2'd3;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] value;
        logic [7:0]         position;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [6:0] found_index;
        logic [7:0] length;
    } out_item_t;

    typedef struct packed {
        logic load_match;
        logic ins;
        logic del;
    } cell_ctl_t;

    typedef struct packed {
        logic done;
        logic hit;
    } scan_stat_t;

endpackage

@@ hw/rtl/pal_cell.sv @@
// One cell of the list chain: holds a single entry and its match flag.
// Shifts toward higher or lower neighbors on insert and delete.
// Depends on pal_pkg.
module pal_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 8,
    parameter int CMP_W = 9
) (
    input  logic               clk,
    input  logic               rst_n,
    input  pal_pkg::cell_ctl_t ctl,
    input  logic [CMP_W-1:0]   pos_m1,
    input  logic [CNT_W-1:0]   count,
    input  logic [31:0]        value,
    input  logic [31:0]        left,
    input  logic [31:0]        right,
    input  logic               last,
    output logic [31:0]        entry,
    output logic               match
);

    logic [31:0] entry_reg;
    logic [31:0] entry_next;
    logic        match_reg;
    logic        match_next;
    logic [CMP_W-1:0] my_idx;

    assign my_idx = CMP_W'(INDEX);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.ins)
        begin
            if (my_idx == pos_m1)
            begin
                entry_next = value;
            end
            else if (my_idx > pos_m1)
            begin
                entry_next = left;
            end
        end
        else if (ctl.del)
        begin
            if (my_idx >= pos_m1 && !last)
            begin
                entry_next = right;
            end
        end
    end

    always_comb
    begin
        match_next = match_reg;
        if (ctl.load_match)
        begin
            match_next = (entry_reg == value) && (CNT_W'(INDEX) < count);
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    assign entry = entry_reg;
    assign match = match_reg;

endmodule

@@ hw/rtl/pal_scan.sv @@
// Lowest-match search over the cell match flags, eight flags per cycle.
// Holds its result until the top level acknowledges it. Depends on pal_pkg.
module pal_scan #(
    parameter int CAPACITY = pal_pkg::CAPACITY_DEF,
    parameter int FI_W     = 7
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                ack,
    input  logic [CAPACITY-1:0] match,
    output pal_pkg::scan_stat_t stat,
    output logic [FI_W-1:0]     index
);

    localparam int GROUP    = pal_pkg::SCAN_GROUP;
    localparam int GRP_BITS = $clog2(GROUP);
    localparam int NGROUPS  = (CAPACITY + GROUP - 1) / GROUP;
    localparam int G_W      = FI_W - GRP_BITS;
    localparam int PAD      = NGROUPS * GROUP - CAPACITY;

    logic [NGROUPS*GROUP-1:0] match_pad;
    logic [GROUP-1:0]         slice;
    logic                     grp_hit;
    logic [GRP_BITS-1:0]      enc;

    logic                run_reg, run_next;
    logic                done_reg, done_next;
    logic                hit_reg, hit_next;
    logic [G_W-1:0]      group_reg, group_next;
    logic [FI_W-1:0]     index_reg, index_next;

    generate
        if (PAD > 0)
        begin : g_pad
            assign match_pad = {{PAD{1'b0}}, match};
        end
        else
        begin : g_nopad
            assign match_pad = match;
        end
    endgenerate

    assign slice = match_pad[group_reg*GROUP +: GROUP];

    always_comb
    begin
        grp_hit = 1'b0;
        enc     = '0;
        for (int b = GROUP - 1; b >= 0; b--)
        begin
            if (slice[b])
            begin
                grp_hit = 1'b1;
                enc     = GRP_BITS'(b);
            end
        end
    end

    always_comb
    begin
        run_next   = run_reg;
        done_next  = done_reg;
        hit_next   = hit_reg;
        group_next = group_reg;
        index_next = index_reg;
        if (start)
        begin
            run_next   = 1'b1;
            done_next  = 1'b0;
            group_next = '0;
        end
        else if (run_reg)
        begin
            if (grp_hit)
            begin
                run_next   = 1'b0;
                done_next  = 1'b1;
                hit_next   = 1'b1;
                index_next = {group_reg, enc};
            end
            else if (group_reg == G_W'(NGROUPS - 1))
            begin
                run_next   = 1'b0;
                done_next  = 1'b1;
                hit_next   = 1'b0;
                index_next = '0;
            end
            else
            begin
                group_next = group_reg + G_W'(1);
            end
        end
        else if (ack)
        begin
            done_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            done_reg  <= 1'b0;
            hit_reg   <= 1'b0;
            group_reg <= '0;
        end
        else
        begin
            run_reg   <= run_next;
            done_reg  <= done_next;
            hit_reg   <= hit_next;
            group_reg <= group_next;
        end
    end

    always_ff @(posedge clk)
    begin
        index_reg <= index_next;
    end

    assign stat.done = done_reg;
    assign stat.hit  = hit_reg;
    assign index     = index_reg;

endmodule

@@ hw/rtl/positional_array_list_unit.sv @@
// Top level of the positional array list unit: handshake, command decode,
// the chain of pal_cell entries and the pal_scan search. Depends on pal_pkg.
//
//   channel  | signals                        | payload
//   ---------+--------------------------------+--------------------
//   input    | in_valid / in_ready / in_data  | pal_pkg::in_item_t
//   output   | out_valid / out_ready / out_data| pal_pkg::out_item_t
//
// Insert, delete and unused commands give their result in the next cycle;
// the result is registered at the edge of the input transfer. Find registers
// the match flags; pal_scan searches them eight per cycle for the result.
// Reset clears the count; entries are written only by insert and shifts.
// A new input transfer is taken only while idle and the output register is
// empty or being emptied, so a stalled output holds the next item off.
module positional_array_list_unit #(
    parameter int CAPACITY = pal_pkg::CAPACITY_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  pal_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output pal_pkg::out_item_t out_data
);

    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = (CNT_W > 8 ? CNT_W : 8) + 1;
    localparam int GROUP    = pal_pkg::SCAN_GROUP;
    localparam int NGROUPS  = (CAPACITY + GROUP - 1) / GROUP;
    localparam int G_W      = (NGROUPS > 1) ? $clog2(NGROUPS) : 1;
    localparam int FI_W     = G_W + $clog2(GROUP);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic out_valid_reg, out_valid_next;
    pal_pkg::out_item_t out_data_reg, out_data_next;

    logic               in_fire;
    logic               slot_free;
    logic [CMP_W-1:0]   pos_ext, cnt_ext, pos_m1;
    logic               is_full, ins_bad, del_bad;
    pal_pkg::cell_ctl_t ctl;
    pal_pkg::scan_stat_t scan_stat;
    logic [FI_W-1:0]    scan_index;
    logic               scan_ack;
    logic [FI_W+6:0]    fi_wide;

    logic [31:0]         entry_w [CAPACITY];
    logic [CAPACITY-1:0] match_w;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && slot_free;
    assign in_fire   = in_valid && in_ready;

    assign pos_ext = CMP_W'(in_data.position);
    assign cnt_ext = CMP_W'(count_reg);
    assign pos_m1  = pos_ext - CMP_W'(1);
    assign is_full = (count_reg == CNT_W'(CAPACITY));
    assign ins_bad = (in_data.position == 8'd0) || (pos_ext > cnt_ext + CMP_W'(1));
    assign del_bad = (in_data.position == 8'd0) || (pos_ext > cnt_ext);

    assign scan_ack = (state_reg == S_SCAN) && scan_stat.done && slot_free;
    assign fi_wide  = {7'd0, scan_index};

    always_comb
    begin
        ctl            = '0;
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        if (in_fire)
        begin
            out_data_next.found_index = '0;
            out_data_next.status      = pal_pkg::STAT_DONE;
            case (in_data.command)
                pal_pkg::CMD_FIND:
                begin
                    ctl.load_match = 1'b1;
                    state_next     = S_SCAN;
                end
                pal_pkg::CMD_INSERT:
                begin
                    if (is_full)
                    begin
                        out_data_next.status = pal_pkg::STAT_FULL;
                    end
                    else if (ins_bad)
                    begin
                        out_data_next.status = pal_pkg::STAT_BAD_POS;
                    end
                    else
                    begin
                        ctl.ins    = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                pal_pkg::CMD_DELETE:
                begin
                    if (del_bad)
                    begin
                        out_data_next.status = pal_pkg::STAT_BAD_POS;
                    end
                    else
                    begin
                        ctl.del    = 1'b1;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                end
            endcase
            if (in_data.command != pal_pkg::CMD_FIND)
            begin
                out_valid_next       = 1'b1;
                out_data_next.length = 8'(count_next);
            end
        end
        else if (scan_ack)
        begin
            state_next                = S_IDLE;
            out_valid_next            = 1'b1;
            out_data_next.length      = 8'(count_reg);
            out_data_next.status      = scan_stat.hit ? pal_pkg::STAT_DONE
                                                      : pal_pkg::STAT_NOT_FOUND;
            out_data_next.found_index = scan_stat.hit ? fi_wide[6:0] : 7'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    generate
        for (genvar i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic [31:0] left_w;
            logic [31:0] right_w;
            if (i == 0)
            begin : g_first
                assign left_w = in_data.value;
            end
            else
            begin : g_mid_l
                assign left_w = entry_w[i-1];
            end
            if (i == CAPACITY - 1)
            begin : g_last
                assign right_w = entry_w[i];
            end
            else
            begin : g_mid_r
                assign right_w = entry_w[i+1];
            end
            pal_cell #(
                .INDEX (i),
                .CNT_W (CNT_W),
                .CMP_W (CMP_W)
            ) u_cell (
                .clk    (clk),
                .rst_n  (rst_n),
                .ctl    (ctl),
                .pos_m1 (pos_m1),
                .count  (count_reg),
                .value  (in_data.value),
                .left   (left_w),
                .right  (right_w),
                .last   (i == CAPACITY - 1),
                .entry  (entry_w[i]),
                .match  (match_w[i])
            );
        end
    endgenerate

    pal_scan #(
        .CAPACITY (CAPACITY),
        .FI_W     (FI_W)
    ) u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctl.load_match),
        .ack   (scan_ack),
        .match (match_w),
        .stat  (scan_stat),
        .index (scan_index)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ hw/rtl/pal_chk.sv @@
// Port-level checker for positional_array_list_unit, attached by bind.
// Depends on pal_pkg and the top level's port list.
module pal_chk (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input pal_pkg::in_item_t  in_data,
    input logic               out_valid,
    input logic               out_ready,
    input pal_pkg::out_item_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("Stalled result changed before its transfer.");

    a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> !out_valid || out_ready)
        else $error("Input transfer taken while the result register is full.");

    a_direct_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.command != pal_pkg::CMD_FIND |=> out_valid)
        else $error("Insert or delete gave no result in the next cycle.");

    a_index_only_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.found_index != 7'd0 |-> out_data.status == pal_pkg::STAT_DONE)
        else $error("Nonzero index reported without a successful find.");

    a_delete_status: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.command == pal_pkg::CMD_DELETE |=>
        out_data.status != pal_pkg::STAT_NOT_FOUND && out_data.status != pal_pkg::STAT_FULL)
        else $error("Delete reported a find or full status.");

endmodule

bind positional_array_list_unit pal_chk u_pal_chk (.*);
